### rtl/css_pkg.sv
// Package for the cutdown safety supervisor: shared constants, register indexes
// and the structures that pass between the register file, the core and the top level.
// It has no dependencies.
`default_nettype none

package css_pkg;

    localparam int unsigned LOCKOUT_MS_DEFAULT = 60000;
    localparam int unsigned MS_PER_S           = 1000;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned LAT_W  = 31;
    localparam int unsigned LON_W  = 32;
    localparam int unsigned ZSEC_W = 23;
    localparam int unsigned MASK_W = 3;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_ENABLE_MASK      = 3'd0;
    localparam logic [2:0] REG_TIMED_DEADLINE   = 3'd1;
    localparam logic [2:0] REG_LAT_MIN          = 3'd2;
    localparam logic [2:0] REG_LAT_MAX          = 3'd3;
    localparam logic [2:0] REG_LON_MIN          = 3'd4;
    localparam logic [2:0] REG_LON_MAX          = 3'd5;
    localparam logic [2:0] REG_ZONE_MAX_SECONDS = 3'd6;
    localparam logic [2:0] REG_DEADMAN          = 3'd7;

    localparam int unsigned EN_TIMED    = 0;
    localparam int unsigned EN_GEOFENCE = 1;
    localparam int unsigned EN_DEADMAN  = 2;

    typedef struct packed {
        logic [MASK_W-1:0]       enable_mask;
        logic [TIME_W-1:0]       timed_deadline_ms;
        logic signed [LAT_W-1:0] lat_min;
        logic signed [LAT_W-1:0] lat_max;
        logic signed [LON_W-1:0] lon_min;
        logic signed [LON_W-1:0] lon_max;
        logic [TIME_W-1:0]       zone_ms;
        logic [TIME_W-1:0]       deadman_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]       now_ms;
        logic signed [LAT_W-1:0] latitude;
        logic signed [LON_W-1:0] longitude;
        logic                    cutdown_request;
        logic                    comm_seen;
    } item_t;

    typedef struct packed {
        logic fire_cutdown;
        logic inside_zone;
        logic cutdown_done;
        logic request_pending;
    } result_t;

endpackage : css_pkg

`default_nettype wire

### rtl/css_regs.sv
// Configuration register file with its APB-style access port.
// Depends on css_pkg; also keeps the dwell time converted to milliseconds.
`default_nettype none

module css_regs
    import css_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output cfg_t                   cfg,
    output logic                   rearm
);

    cfg_t              cfg_reg;
    logic [ZSEC_W-1:0] zone_max_seconds_reg;
    logic              wr_en;
    logic [2:0]        wr_index;
    logic [32:0]       zone_prod;

    assign wr_en     = psel && penable && pwrite;
    assign wr_index  = paddr[4:2];
    assign zone_prod = 33'(pwdata[ZSEC_W-1:0]) * 33'(MS_PER_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            zone_max_seconds_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ENABLE_MASK:      cfg_reg.enable_mask       <= pwdata[MASK_W-1:0];
                REG_TIMED_DEADLINE:   cfg_reg.timed_deadline_ms <= pwdata;
                REG_LAT_MIN:          cfg_reg.lat_min           <= pwdata[LAT_W-1:0];
                REG_LAT_MAX:          cfg_reg.lat_max           <= pwdata[LAT_W-1:0];
                REG_LON_MIN:          cfg_reg.lon_min           <= pwdata;
                REG_LON_MAX:          cfg_reg.lon_max           <= pwdata;
                REG_ZONE_MAX_SECONDS:
                begin
                    zone_max_seconds_reg <= pwdata[ZSEC_W-1:0];
                    cfg_reg.zone_ms      <= zone_prod[TIME_W-1:0];
                end
                REG_DEADMAN:          cfg_reg.deadman_ms        <= pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_index)
            REG_ENABLE_MASK:      prdata = {29'd0, cfg_reg.enable_mask};
            REG_TIMED_DEADLINE:   prdata = cfg_reg.timed_deadline_ms;
            REG_LAT_MIN:          prdata = 32'(cfg_reg.lat_min);
            REG_LAT_MAX:          prdata = 32'(cfg_reg.lat_max);
            REG_LON_MIN:          prdata = cfg_reg.lon_min;
            REG_LON_MAX:          prdata = cfg_reg.lon_max;
            REG_ZONE_MAX_SECONDS: prdata = {9'd0, zone_max_seconds_reg};
            REG_DEADMAN:          prdata = cfg_reg.deadman_ms;
            default:              prdata = '0;
        endcase
    end

    assign cfg   = cfg_reg;
    assign rearm = wr_en && (wr_index == REG_ENABLE_MASK);

endmodule : css_regs

`default_nettype wire

### rtl/css_core.sv
// Supervisor state and the single-pass trigger and firing logic for one request.
// Depends on css_pkg; state advances as requests move on; rearm acts at once.
`default_nettype none

module css_core
    import css_pkg::*;
#(
    parameter int unsigned LOCKOUT_MS = LOCKOUT_MS_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire logic  rearm,
    input  wire cfg_t  cfg,
    input  wire item_t item,
    output result_t    result
);

    logic [TIME_W-1:0] last_fire_ms_reg,     last_fire_ms_next;
    logic              pending_reg,          pending_next;
    logic              zone_flag_reg,        zone_flag_next;
    logic [TIME_W-1:0] zone_deadline_ms_reg, zone_deadline_ms_next;
    logic              timed_spent_reg,      timed_spent_next;
    logic [TIME_W-1:0] last_comm_ms_reg,     last_comm_ms_next;
    logic              done_flag_reg,        done_flag_next;

    logic              in_box;
    logic              timed_hit;
    logic              geo_hit;
    logic              dead_hit;
    logic              pend;
    logic              fire;
    logic [TIME_W-1:0] silence;
    logic [TIME_W-1:0] since_fire;

    always_comb
    begin
        in_box = (item.latitude > cfg.lat_min) && (item.latitude < cfg.lat_max)
              && (item.longitude > cfg.lon_min) && (item.longitude < cfg.lon_max);

        last_comm_ms_next = item.comm_seen ? item.now_ms : last_comm_ms_reg;

        timed_hit = cfg.enable_mask[EN_TIMED] && !timed_spent_reg
                 && (item.now_ms > cfg.timed_deadline_ms);

        zone_flag_next        = zone_flag_reg;
        zone_deadline_ms_next = zone_deadline_ms_reg;
        geo_hit               = 1'b0;
        if (cfg.enable_mask[EN_GEOFENCE])
        begin
            zone_flag_next = in_box;
            if (in_box && !zone_flag_reg)
            begin
                zone_deadline_ms_next = item.now_ms + cfg.zone_ms;
            end
            geo_hit = in_box && (item.now_ms > zone_deadline_ms_next);
        end

        silence  = item.now_ms - last_comm_ms_next;
        dead_hit = cfg.enable_mask[EN_DEADMAN] && (silence > cfg.deadman_ms);

        pend       = pending_reg || item.cutdown_request || timed_hit || geo_hit || dead_hit;
        since_fire = item.now_ms - last_fire_ms_reg;
        fire       = pend && (since_fire >= TIME_W'(LOCKOUT_MS));

        pending_next      = pend && !fire;
        done_flag_next    = done_flag_reg || fire;
        last_fire_ms_next = fire ? item.now_ms : last_fire_ms_reg;

        if (rearm)
        begin
            timed_spent_next = 1'b0;
        end
        else if (advance && timed_hit)
        begin
            timed_spent_next = 1'b1;
        end
        else
        begin
            timed_spent_next = timed_spent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fire_ms_reg     <= '0;
            pending_reg          <= 1'b0;
            zone_flag_reg        <= 1'b0;
            zone_deadline_ms_reg <= '0;
            last_comm_ms_reg     <= '0;
            done_flag_reg        <= 1'b0;
        end
        else if (advance)
        begin
            last_fire_ms_reg     <= last_fire_ms_next;
            pending_reg          <= pending_next;
            zone_flag_reg        <= zone_flag_next;
            zone_deadline_ms_reg <= zone_deadline_ms_next;
            last_comm_ms_reg     <= last_comm_ms_next;
            done_flag_reg        <= done_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timed_spent_reg <= 1'b0;
        end
        else
        begin
            timed_spent_reg <= timed_spent_next;
        end
    end

    assign result.fire_cutdown    = fire;
    assign result.inside_zone     = in_box;
    assign result.cutdown_done    = done_flag_next;
    assign result.request_pending = pending_next;

endmodule : css_core

`default_nettype wire

### rtl/cutdown_safety_supervisor.sv
// Cutdown safety supervisor top level: input register, core and result register.
// The input register takes a request, the result register its result; the core logic
// between them sets the rate of one request per cycle while results are taken. A
// stalled result holds the input register; it frees in the cycle the result is taken.
// Reset (rst_n, asynchronous, active low) clears the valid flags, the configuration
// and the supervisor state; the request and result data registers are not reset.
// Depends on css_pkg, css_regs and css_core.
`default_nettype none

module cutdown_safety_supervisor
    import css_pkg::*;
#(
    parameter int unsigned LOCKOUT_MS = LOCKOUT_MS_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic      [DATA_W-1:0]       prdata,
    output logic                         pready,
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire logic [TIME_W-1:0]       now_ms,
    input  wire logic signed [LAT_W-1:0] latitude,
    input  wire logic signed [LON_W-1:0] longitude,
    input  wire logic                    cutdown_request,
    input  wire logic                    comm_seen,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output logic                         fire_cutdown,
    output logic                         inside_zone,
    output logic                         cutdown_done,
    output logic                         request_pending
);

    cfg_t    cfg;
    logic    rearm;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t core_result;
    logic    advance;

    css_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .rearm   (rearm)
    );

    css_core #(
        .LOCKOUT_MS (LOCKOUT_MS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rearm   (rearm),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (core_result)
    );

    assign pready     = 1'b1;
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.now_ms          <= now_ms;
            item_reg.latitude        <= latitude;
            item_reg.longitude       <= longitude;
            item_reg.cutdown_request <= cutdown_request;
            item_reg.comm_seen       <= comm_seen;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid    = out_valid_reg;
    assign fire_cutdown    = result_reg.fire_cutdown;
    assign inside_zone     = result_reg.inside_zone;
    assign cutdown_done    = result_reg.cutdown_done;
    assign request_pending = result_reg.request_pending;

`ifndef NO_ASSERTIONS
    // A firing always leaves the sticky flag set and the request cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && fire_cutdown) |-> (cutdown_done && !request_pending))
        else $error("Firing result without done flag or with request still pending.");

    // A request moved through the core always produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("Processed request did not produce a result.");

    // Once set, the done flag stays set when requests advance back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && $past(advance) && $past(core_result.cutdown_done))
            |-> core_result.cutdown_done)
        else $error("Cutdown done flag cleared after being set.");
`endif

endmodule : cutdown_safety_supervisor

`default_nettype wire

### dv/cutdown_safety_supervisor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cutdown_safety_supervisor: directed and random ticks,
// configuration over APB, random idling on both streams and a checker per result.
// Depends on css_pkg and the cutdown_safety_supervisor RTL.

module cutdown_safety_supervisor_tb;
    import css_pkg::*;

    localparam logic [TIME_W-1:0] LOCKOUT = LOCKOUT_MS_DEFAULT;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    item_valid;
    logic                    item_ready;
    logic [TIME_W-1:0]       now_ms;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic                    cutdown_request;
    logic                    comm_seen;
    logic                    result_valid;
    logic                    result_ready;
    logic                    fire_cutdown;
    logic                    inside_zone;
    logic                    cutdown_done;
    logic                    request_pending;

    logic [MASK_W-1:0]       cfg_enable = '0;
    logic [TIME_W-1:0]       cfg_deadline = '0;
    logic signed [LAT_W-1:0] cfg_lat_min = '0;
    logic signed [LAT_W-1:0] cfg_lat_max = '0;
    logic signed [LON_W-1:0] cfg_lon_min = '0;
    logic signed [LON_W-1:0] cfg_lon_max = '0;
    logic [ZSEC_W-1:0]       cfg_zone_s = '0;
    logic [TIME_W-1:0]       cfg_deadman = '0;

    logic [TIME_W-1:0]       st_last_fire = '0;
    logic                    st_pending = 1'b0;
    logic                    st_zone_flag = 1'b0;
    logic [TIME_W-1:0]       st_zone_deadline = '0;
    logic                    st_timed_spent = 1'b0;
    logic [TIME_W-1:0]       st_last_comm = '0;
    logic                    st_done = 1'b0;

    result_t                 verdicts[$];
    logic [TIME_W-1:0]       clock_ms = 32'd700000;
    bit                      idle_on = 1'b1;
    int                      hold_req = 0;
    int                      errors = 0;
    int                      ticks_sent = 0;
    int                      writes_done = 0;
    int                      fires_seen = 0;
    int                      inside_seen = 0;

    cutdown_safety_supervisor dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic result_t judge_tick(input item_t t);
        result_t                 r;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic                    in_box;
        lat = t.latitude;
        lon = t.longitude;
        r = '0;
        if (t.comm_seen)
            st_last_comm = t.now_ms;
        if (t.cutdown_request)
            st_pending = 1'b1;
        if (cfg_enable[EN_TIMED] && !st_timed_spent && t.now_ms > cfg_deadline)
        begin
            st_pending = 1'b1;
            st_timed_spent = 1'b1;
        end
        in_box = lat > cfg_lat_min && lat < cfg_lat_max && lon > cfg_lon_min && lon < cfg_lon_max;
        if (cfg_enable[EN_GEOFENCE])
        begin
            if (st_zone_flag && !in_box)
                st_zone_flag = 1'b0;
            if (!st_zone_flag && in_box)
            begin
                st_zone_flag = 1'b1;
                st_zone_deadline = t.now_ms + 32'(cfg_zone_s) * MS_PER_S;
            end
            if (st_zone_flag && t.now_ms > st_zone_deadline)
                st_pending = 1'b1;
        end
        if (cfg_enable[EN_DEADMAN] && (t.now_ms - st_last_comm) > cfg_deadman)
            st_pending = 1'b1;
        if ((t.now_ms - st_last_fire) >= LOCKOUT && st_pending)
        begin
            r.fire_cutdown = 1'b1;
            st_pending = 1'b0;
            st_done = 1'b1;
            st_last_fire = t.now_ms;
        end
        r.inside_zone = in_box;
        r.cutdown_done = st_done;
        r.request_pending = st_pending;
        return r;
    endfunction

    function automatic item_t tick_at(input logic [TIME_W-1:0] now, input longint lat,
                                      input longint lon, input logic req, input logic comm);
        item_t t;
        t.now_ms = now;
        t.latitude = LAT_W'(lat);
        t.longitude = LON_W'(lon);
        t.cutdown_request = req;
        t.comm_seen = comm;
        return t;
    endfunction

    function automatic longint pick_coord(input longint lo, input longint hi);
        case ($urandom_range(0, 5))
            0: return lo + longint'($urandom_range(0, 2)) - 1;
            1: return hi + longint'($urandom_range(0, 2)) - 1;
            2, 3: return (lo + hi) / 2 + longint'($urandom_range(0, 400)) - 200;
            default: return longint'({$urandom, $urandom});
        endcase
    endfunction

    function automatic item_t roam_tick();
        item_t             t;
        logic [TIME_W-1:0] step;
        step = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: step = $urandom_range(0, 3000);
            5, 6: step = $urandom_range(20000, 70000);
            7: step = $urandom_range(0, 200);
            8: step = $urandom;
            default:
            begin
                t.now_ms = $urandom;
                t.latitude = LAT_W'($urandom);
                t.longitude = $urandom;
                t.cutdown_request = 1'($urandom_range(0, 1));
                t.comm_seen = 1'($urandom_range(0, 1));
                return t;
            end
        endcase
        clock_ms = clock_ms + step;
        return tick_at(clock_ms, pick_coord(cfg_lat_min, cfg_lat_max),
                       pick_coord(cfg_lon_min, cfg_lon_max),
                       $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
    endfunction

    task automatic send_tick(input item_t t);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_valid <= 1'b1;
        now_ms <= t.now_ms;
        latitude <= t.latitude;
        longitude <= t.longitude;
        cutdown_request <= t.cutdown_request;
        comm_seen <= t.comm_seen;
        do @(posedge clk); while (!item_ready);
        verdicts.push_back(judge_tick(t));
        ticks_sent++;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ENABLE_MASK:
            begin
                cfg_enable = value[MASK_W-1:0];
                st_timed_spent = 1'b0;
            end
            REG_TIMED_DEADLINE: cfg_deadline = value;
            REG_LAT_MIN: cfg_lat_min = value[LAT_W-1:0];
            REG_LAT_MAX: cfg_lat_max = value[LAT_W-1:0];
            REG_LON_MIN: cfg_lon_min = value;
            REG_LON_MAX: cfg_lon_max = value;
            REG_ZONE_MAX_SECONDS: cfg_zone_s = value[ZSEC_W-1:0];
            REG_DEADMAN: cfg_deadman = value;
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        writes_done++;
    endtask

    task automatic random_config(input int style);
        logic [DATA_W-1:0] en, dl, la0, la1, lo0, lo1, zs, dm;
        longint            lat_c, lon_c, lat_h, lon_h;
        case (style)
            0:
            begin
                en = 32'd7;           dl = 32'd0;
                la0 = 32'h4000_0000;  la1 = 32'h3FFF_FFFF;
                lo0 = 32'h8000_0000;  lo1 = 32'h7FFF_FFFF;
                zs = 32'h007F_FFFF;   dm = 32'hFFFF_FFFF;
            end
            1:
            begin
                en = 32'd0;                 dl = 32'hFFFF_FFFF;
                la0 = 32'(900000000);       la1 = 32'(-900000000);
                lo0 = 32'(1800000000);      lo1 = 32'(-1800000000);
                zs = 32'd0;                 dm = 32'd0;
            end
            2:
            begin
                en = 32'd7;                 dl = 32'hFFFF_FFFF;
                la0 = 32'(-900000000);      la1 = 32'(900000000);
                lo0 = 32'(-1800000000);     lo1 = 32'(1800000000);
                zs = 32'd0;                 dm = 32'd0;
            end
            default:
            begin
                lat_c = longint'($urandom_range(0, 1798000000)) - 899000000;
                lon_c = longint'($urandom_range(0, 2000000000)) * 2 - 1798000000;
                lat_h = longint'($urandom_range(0, 20000));
                lon_h = longint'($urandom_range(0, 20000));
                en = $urandom_range(0, 7);
                dl = clock_ms + $urandom_range(0, 300000);
                la0 = 32'(lat_c - lat_h);   la1 = 32'(lat_c + lat_h);
                lo0 = 32'(lon_c - lon_h);   lo1 = 32'(lon_c + lon_h);
                zs = $urandom_range(0, 30);
                dm = $urandom_range(0, 120000);
            end
        endcase
        write_reg(REG_TIMED_DEADLINE, dl);
        write_reg(REG_LAT_MIN, la0);
        write_reg(REG_LAT_MAX, la1);
        write_reg(REG_LON_MIN, lo0);
        write_reg(REG_LON_MAX, lo1);
        write_reg(REG_ZONE_MAX_SECONDS, zs);
        write_reg(REG_DEADMAN, dm);
        write_reg(REG_ENABLE_MASK, en);
    endtask

    // With every trigger disabled only the external request can fire, and the startup
    // lockout must hold it back until sixty seconds have passed.
    task automatic test_reset_defaults();
        send_tick(tick_at(32'd0, 0, 0, 1'b1, 1'b0));
        send_tick(tick_at(32'd59999, 1073741823, -2147483648, 1'b0, 1'b1));
        send_tick(tick_at(32'd60000, -1073741824, 2147483647, 1'b0, 1'b0));
        send_tick(tick_at(32'hFFFF_FFFF, 900000000, -1800000000, 1'b1, 1'b1));
        send_tick(tick_at(32'd5, -900000000, 1800000000, 1'b0, 1'b0));
        settle();
    endtask

    task automatic test_directed_triggers();
        write_reg(REG_TIMED_DEADLINE, 32'd100000);
        write_reg(REG_LAT_MIN, 32'(-1000));
        write_reg(REG_LAT_MAX, 32'd1000);
        write_reg(REG_LON_MIN, 32'(-2000));
        write_reg(REG_LON_MAX, 32'd2000);
        write_reg(REG_ZONE_MAX_SECONDS, 32'd5);
        write_reg(REG_DEADMAN, 32'd30000);
        write_reg(REG_ENABLE_MASK, 32'd7);
        send_tick(tick_at(32'd200000, 0, 0, 1'b0, 1'b1));
        send_tick(tick_at(32'd204000, 0, 0, 1'b0, 1'b1));
        send_tick(tick_at(32'd205001, 999, 1999, 1'b0, 1'b1));
        send_tick(tick_at(32'd260001, 1000, 0, 1'b0, 1'b1));
        send_tick(tick_at(32'd260500, -999, -1999, 1'b0, 1'b1));
        send_tick(tick_at(32'd266000, 0, 0, 1'b0, 1'b0));
        send_tick(tick_at(32'd300000, 0, 2000, 1'b0, 1'b0));
        send_tick(tick_at(32'd330001, 0, 5000, 1'b0, 1'b0));
        send_tick(tick_at(32'd330002, 0, 5000, 1'b0, 1'b0));
        send_tick(tick_at(32'd400000, 0, 5000, 1'b0, 1'b1));
        settle();
    endtask

    // Rewriting the enable mask re-arms the one-shot timer; the longest zone dwell
    // wraps when converted to milliseconds, so the stored dwell is truncated.
    task automatic test_timed_rearm();
        write_reg(REG_TIMED_DEADLINE, 32'd0);
        write_reg(REG_ZONE_MAX_SECONDS, 32'h007F_FFFF);
        write_reg(REG_ENABLE_MASK, 32'd3);
        send_tick(tick_at(32'd500000, 0, 0, 1'b0, 1'b0));
        send_tick(tick_at(32'd500001, 0, 0, 1'b0, 1'b0));
        send_tick(tick_at(32'hFFFF_FFF0, 0, 0, 1'b0, 1'b0));
        send_tick(tick_at(32'd600000, 0, 0, 1'b1, 1'b0));
        settle();
    endtask

    task automatic test_backpressure();
        int k;
        idle_on = 1'b0;
        hold_req = 40;
        for (k = 0; k < 30; k++)
            send_tick(roam_tick());
        settle();
    endtask

    task automatic test_random_phases();
        int p, k;
        for (p = 0; p < 9; p++)
        begin
            random_config(p);
            idle_on = (p < 2) || ($urandom_range(0, 3) != 0);
            for (k = 0; k < 100; k++)
                send_tick(roam_tick());
            settle();
        end
    endtask

    task automatic test_steady_stream();
        int k;
        random_config(3);
        idle_on = 1'b0;
        for (k = 0; k < 150; k++)
            send_tick(roam_tick());
        settle();
    endtask

    function automatic void check_bit(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (verdicts.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                errors++;
            end
            else
            begin
                want = verdicts.pop_front();
                check_bit("fire_cutdown", want.fire_cutdown, fire_cutdown);
                check_bit("inside_zone", want.inside_zone, inside_zone);
                check_bit("cutdown_done", want.cutdown_done, cutdown_done);
                check_bit("request_pending", want.request_pending, request_pending);
                fires_seen += int'(fire_cutdown);
                inside_seen += int'(inside_zone);
            end
        end
    end

    initial
    begin : result_sink
        int n;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
                result_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        #2000000;
        $display("cutdown_safety_supervisor verification failed");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_valid <= 1'b0;
        now_ms <= '0;
        latitude <= '0;
        longitude <= '0;
        cutdown_request <= 1'b0;
        comm_seen <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_triggers();
        test_timed_rearm();
        test_backpressure();
        test_random_phases();
        test_steady_stream();
        repeat (10) @(posedge clk);
        $display("Summary: %0d ticks checked across %0d register writes.", ticks_sent, writes_done);
        $display("Summary: %0d cutdown pulses and %0d in-zone ticks observed.",
                 fires_seen, inside_seen);
        if (errors == 0)
            $display("cutdown_safety_supervisor verification clean");
        else
            $display("cutdown_safety_supervisor verification failed");
        $finish;
    end

endmodule

### files.f
rtl/css_pkg.sv
rtl/css_regs.sv
rtl/css_core.sv
rtl/cutdown_safety_supervisor.sv
dv/cutdown_safety_supervisor_tb.sv
